// ===== src/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants for the text console character engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int OP_W     = 3;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 8;
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int CELL_W   = 16;
  localparam int POS_W    = 16;
  localparam int OFFSET_W = 14;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 14;

  typedef logic [CELL_W-1:0] cell_t;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUT_CHAR   = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_CURSOR = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE_CELL = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_CELL  = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_OFFSET = 1'd1;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;
  localparam logic [CHAR_W-1:0] CH_DELETE    = 8'd127;
  localparam logic [CHAR_W-1:0] CH_SUBST     = 8'd63;

  localparam logic [COL_W:0] TAB_STEP = 8'd4;
  localparam logic [COL_W:0] TAB_MASK = ~(TAB_STEP - 8'd1);

  localparam logic [COLOR_W-1:0]  TEXT_COLOR_RST     = 8'd10;
  localparam logic [OFFSET_W-1:0] DISPLAY_OFFSET_RST = 14'd2;

  function automatic cell_t make_cell(input logic [CHAR_W-1:0] ch,
                                      input logic [COLOR_W-1:0] color);
    make_cell = {color, ch};
  endfunction

endpackage

// ===== src/tcce_if.sv =====
// ----------------------------------------------------------------------------
// tcce_if
// Valid/ready channels for command beats and response beats.
// ----------------------------------------------------------------------------
interface tcce_cmd_if
  import tcce_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [CHAR_W-1:0]  char_code;
  logic [COLOR_W-1:0] cell_color;
  logic [COL_W-1:0]   pos_x;
  logic [ROW_W-1:0]   pos_y;

  modport source (output valid, operation, char_code, cell_color, pos_x, pos_y,
                  input ready);
  modport sink   (input valid, operation, char_code, cell_color, pos_x, pos_y,
                  output ready);
endinterface

interface tcce_rsp_if
  import tcce_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_word;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_column;
  logic [POS_W-1:0]  cursor_position;

  modport source (output valid, cell_word, cursor_row, cursor_column, cursor_position,
                  input ready);
  modport sink   (input valid, cell_word, cursor_row, cursor_column, cursor_position,
                  output ready);
endinterface

// ===== src/tcce_ram.sv =====
// ----------------------------------------------------------------------------
// tcce_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/text_console_character_engine.sv =====
// ----------------------------------------------------------------------------
// text_console_character_engine
// Text-mode console: cell grid in RAM, cursor, put-char, clear, scroll.
//
//   channel | dir | beat contents
//   --------+-----+----------------------------------------------------------
//   cmd     | in  | operation, char_code, cell_color, pos_x, pos_y
//   rsp     | out | cell_word, cursor_row, cursor_column, cursor_position
//   cfg     | in  | cfg_we, cfg_index, cfg_wdata (write only)
//
// Most commands are accepted (cell write or read issued), then the response
// register is loaded. A scroll first copies the grid up one row, one cell per
// cycle through the single RAM write port, then blanks the bottom row; clear
// screen first blanks every cell. After reset the RAM is swept with blanks
// before cmd.ready rises. A stalled response holds in its register while the
// next command is accepted.
// ----------------------------------------------------------------------------
module text_console_character_engine
  import tcce_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  tcce_cmd_if.sink              cmd,
  tcce_rsp_if.source            rsp
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(COLUMNS * (ROWS - 1));
  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_COPY   = 3'd2;
  localparam logic [2:0] ST_FILL   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    cell_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c));
  endfunction

  logic [2:0]          state, state_next;
  logic [ADDR_W-1:0]   cnt, cnt_next;
  logic [ROW_W-1:0]    row, row_next;
  logic [COL_W-1:0]    col, col_next;
  logic                word_hit, word_hit_next;
  logic [COLOR_W-1:0]  text_color;
  logic [OFFSET_W-1:0] display_offset;

  logic                rsp_valid;
  logic [CELL_W-1:0]   rsp_word;
  logic [ROW_W-1:0]    rsp_row;
  logic [COL_W-1:0]    rsp_col;
  logic [POS_W-1:0]    rsp_pos;

  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  cell_t               ram_wdata, ram_rdata;

  logic                accept, load_rsp, go_next_row, in_range;
  logic [COL_W:0]      col_inc, col_tab;
  logic [ROW_W-1:0]    bs_row;
  logic [COL_W-1:0]    bs_col;
  logic [CHAR_W-1:0]   print_char;

  tcce_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign load_rsp  = (state == ST_FINISH) && (!rsp_valid || rsp.ready);

  assign in_range = ({1'b0, cmd.pos_x} < (COL_W+1)'(COLUMNS)) &&
                    ({1'b0, cmd.pos_y} < (ROW_W+1)'(ROWS));
  assign col_inc  = {1'b0, col} + (COL_W+1)'(1);
  assign col_tab  = ({1'b0, col} + TAB_STEP) & TAB_MASK;
  assign print_char = (cmd.char_code >= CH_DELETE) ? CH_SUBST : cmd.char_code;

  // backspace target: step left, wrap to previous row end, stick at origin
  always_comb begin
    bs_row = row;
    bs_col = col;
    if (col != '0) begin
      bs_col = col - COL_W'(1);
    end else if (row != '0) begin
      bs_row = row - ROW_W'(1);
      bs_col = COL_LAST;
    end
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    row_next      = row;
    col_next      = col;
    word_hit_next = word_hit;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    go_next_row   = 1'b0;

    case (state)
      ST_INIT, ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = (state == ST_INIT) ? make_cell(CH_SPACE, TEXT_COLOR_RST)
                                       : make_cell(CH_SPACE, text_color);
        if (cnt == CELL_LAST) begin
          state_next = (state == ST_INIT) ? ST_IDLE : ST_FINISH;
        end else begin
          cnt_next = cnt + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        if (accept) begin
          state_next    = ST_FINISH;
          word_hit_next = 1'b0;
          case (cmd.operation)
            OP_PUT_CHAR: begin
              if (cmd.char_code == CH_NEWLINE) begin
                go_next_row = 1'b1;
              end else if (cmd.char_code == CH_BACKSPACE) begin
                row_next  = bs_row;
                col_next  = bs_col;
                ram_we    = 1'b1;
                ram_waddr = cell_addr(bs_row, bs_col);
                ram_wdata = make_cell(CH_SPACE, text_color);
              end else if (cmd.char_code == CH_TAB) begin
                if (col_tab >= (COL_W+1)'(COLUMNS)) begin
                  go_next_row = 1'b1;
                end else begin
                  col_next = col_tab[COL_W-1:0];
                end
              end else if (cmd.char_code >= CH_SPACE) begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr(row, col);
                ram_wdata = make_cell(print_char, text_color);
                if (col_inc >= (COL_W+1)'(COLUMNS)) begin
                  go_next_row = 1'b1;
                end else begin
                  col_next = col_inc[COL_W-1:0];
                end
              end
            end
            OP_CLEAR: begin
              row_next   = '0;
              col_next   = '0;
              cnt_next   = '0;
              state_next = ST_FILL;
            end
            OP_SET_CURSOR: begin
              col_next = ({1'b0, cmd.pos_x} >= (COL_W+1)'(COLUMNS)) ? COL_LAST : cmd.pos_x;
              row_next = ({1'b0, cmd.pos_y} >= (ROW_W+1)'(ROWS)) ? ROW_LAST : cmd.pos_y;
            end
            OP_WRITE_CELL: begin
              if (in_range) begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr(cmd.pos_y, cmd.pos_x);
                ram_wdata = make_cell(cmd.char_code, cmd.cell_color);
              end
            end
            OP_READ_CELL: begin
              if (in_range) begin
                ram_re        = 1'b1;
                ram_raddr     = cell_addr(cmd.pos_y, cmd.pos_x);
                word_hit_next = 1'b1;
              end
            end
            default: begin
            end
          endcase

          if (go_next_row) begin
            col_next = '0;
            if (row == ROW_LAST) begin
              cnt_next   = '0;
              state_next = ST_COPY;
            end else begin
              row_next = row + ROW_W'(1);
            end
          end
        end
      end

      // scroll: read one row ahead, write the previous read one cell back
      ST_COPY: begin
        if (cnt != '0) begin
          ram_we    = 1'b1;
          ram_waddr = cnt - ADDR_W'(1);
          ram_wdata = ram_rdata;
        end
        if (cnt == COPY_LAST) begin
          state_next = ST_FILL;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(cnt + ADDR_W'(COLUMNS));
          cnt_next  = cnt + ADDR_W'(1);
        end
      end

      ST_FINISH: begin
        if (load_rsp) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_INIT;
      cnt            <= '0;
      row            <= '0;
      col            <= '0;
      word_hit       <= 1'b0;
      rsp_valid      <= 1'b0;
      text_color     <= TEXT_COLOR_RST;
      display_offset <= DISPLAY_OFFSET_RST;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      row      <= row_next;
      col      <= col_next;
      word_hit <= word_hit_next;

      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_TEXT_COLOR:     text_color     <= cfg_wdata[COLOR_W-1:0];
          CFG_DISPLAY_OFFSET: display_offset <= cfg_wdata[OFFSET_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp_word <= word_hit ? ram_rdata : '0;
      rsp_row  <= row;
      rsp_col  <= col;
      rsp_pos  <= POS_W'(POS_W'(row) * POS_W'(COLUMNS) + POS_W'(col) +
                         POS_W'(display_offset));
    end
  end

  assign rsp.valid           = rsp_valid;
  assign rsp.cell_word       = rsp_word;
  assign rsp.cursor_row      = rsp_row;
  assign rsp.cursor_column   = rsp_col;
  assign rsp.cursor_position = rsp_pos;

endmodule

// ===== src/tcce_checker.sv =====
// ----------------------------------------------------------------------------
// tcce_checker
// Port-level checks for the console engine, bound to the top level.
// ----------------------------------------------------------------------------
module tcce_checker
  import tcce_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic              clk,
  input logic              rst,
  input logic              cmd_valid,
  input logic              cmd_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [CELL_W-1:0] cell_word,
  input logic [ROW_W-1:0]  cursor_row,
  input logic [COL_W-1:0]  cursor_column,
  input logic [POS_W-1:0]  cursor_position
);

  logic       cmd_beat, rsp_beat;
  logic [1:0] in_flight;

  assign cmd_beat = cmd_valid && cmd_ready;
  assign rsp_beat = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + 2'(cmd_beat) - 2'(rsp_beat);
    end
  end

  // a stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(cell_word) &&
      $stable(cursor_row) && $stable(cursor_column) && $stable(cursor_position))
    else $error("response changed while stalled");

  // one command at a time: ready drops right after a command beat
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_beat |=> !cmd_ready)
    else $error("command accepted while previous one still in work");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ({1'b0, cursor_row} < (ROW_W+1)'(ROWS)) &&
                  ({1'b0, cursor_column} < (COL_W+1)'(COLUMNS)))
    else $error("reported cursor outside the grid");

  // at most one response waiting plus one command in work
  a_no_extra_rsp: assert property (@(posedge clk) disable iff (rst)
    (in_flight != 2'd3) && (!rsp_valid || (in_flight != 2'd0)))
    else $error("response without a matching command");

endmodule

bind text_console_character_engine tcce_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcce_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .cell_word       (rsp.cell_word),
  .cursor_row      (rsp.cursor_row),
  .cursor_column   (rsp.cursor_column),
  .cursor_position (rsp.cursor_position)
);
